// ===== src/fpa_pkg.sv =====
// Shared types, constants and command codes for the fixed-point ALU.
package fpa_pkg;

	localparam int unsigned FracBitsDefault = 8;
	localparam int unsigned WordW = 32;
	localparam int unsigned CmdW = 4;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [CmdW-1:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_INC      = 4'd4,
		CMD_DEC      = 4'd5,
		CMD_MIN      = 4'd6,
		CMD_MAX      = 4'd7,
		CMD_FROM_INT = 4'd8,
		CMD_TO_INT   = 4'd9
	} cmd_t;

	// Which back-end unit produces the result.
	typedef enum logic [1:0] {
		UNIT_SIMPLE = 2'd0,
		UNIT_MUL    = 2'd1,
		UNIT_DIV    = 2'd2,
		UNIT_ZERO   = 2'd3
	} unit_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		unit_t              unit;
		logic [WordW-1:0]   simple_res;
		logic signed [WordW-1:0] a;
		logic signed [WordW-1:0] b;
		logic               less;
		logic               equal;
		logic               greater;
		logic               div_zero;
	} op_t;

	typedef struct packed {
		logic [WordW-1:0] result;
		logic             a_less;
		logic             a_equal;
		logic             a_greater;
		logic             divide_error;
	} res_t;

endpackage

// ===== src/fpa_if.sv =====
// Valid/ready channel interfaces for the ALU's input and output.
interface fpa_in_if;
	logic                          valid;
	logic                          ready;
	logic [fpa_pkg::CmdW-1:0]      command;
	logic signed [fpa_pkg::WordW-1:0] operand_a;
	logic signed [fpa_pkg::WordW-1:0] operand_b;
	modport source (output valid, command, operand_a, operand_b, input ready);
	modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [fpa_pkg::WordW-1:0] result;
	logic                          a_less;
	logic                          a_equal;
	logic                          a_greater;
	logic                          divide_error;
	modport source (output valid, result, a_less, a_equal, a_greater, divide_error,
		input ready);
	modport sink (input valid, result, a_less, a_equal, a_greater, divide_error,
		output ready);
endinterface

// ===== src/fpa_front.sv =====
// Front end: accepts beats, compares operands, computes the simple commands.
module fpa_front #(
	parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	fpa_in_if.sink          in_ch,
	output logic            op_valid,
	input  logic            op_ready,
	output fpa_pkg::op_t    op
);
	localparam int unsigned W = fpa_pkg::WordW;

	logic         valid_s1;
	fpa_pkg::op_t op_s1;
	fpa_pkg::op_t op_d;

	assign in_ch.ready = !valid_s1 || op_ready;
	assign op_valid = valid_s1;
	assign op = op_s1;

	always_comb begin
		op_d = '0;
		op_d.a = in_ch.operand_a;
		op_d.b = in_ch.operand_b;
		op_d.less = in_ch.operand_a < in_ch.operand_b;
		op_d.equal = in_ch.operand_a == in_ch.operand_b;
		op_d.greater = in_ch.operand_a > in_ch.operand_b;
		op_d.unit = fpa_pkg::UNIT_SIMPLE;
		case (in_ch.command)
			fpa_pkg::CMD_ADD: op_d.simple_res = in_ch.operand_a + in_ch.operand_b;
			fpa_pkg::CMD_SUB: op_d.simple_res = in_ch.operand_a - in_ch.operand_b;
			fpa_pkg::CMD_MUL: op_d.unit = fpa_pkg::UNIT_MUL;
			fpa_pkg::CMD_DIV: begin
				if (in_ch.operand_b == '0) begin
					op_d.div_zero = 1'b1;
					op_d.unit = fpa_pkg::UNIT_ZERO;
				end else begin
					op_d.unit = fpa_pkg::UNIT_DIV;
				end
			end
			fpa_pkg::CMD_INC: op_d.simple_res = in_ch.operand_a + W'(1);
			fpa_pkg::CMD_DEC: op_d.simple_res = in_ch.operand_a - W'(1);
			fpa_pkg::CMD_MIN: op_d.simple_res =
				(in_ch.operand_a < in_ch.operand_b) ? in_ch.operand_a : in_ch.operand_b;
			fpa_pkg::CMD_MAX: op_d.simple_res =
				(in_ch.operand_a > in_ch.operand_b) ? in_ch.operand_a : in_ch.operand_b;
			fpa_pkg::CMD_FROM_INT: op_d.simple_res = in_ch.operand_a << FRAC_BITS;
			fpa_pkg::CMD_TO_INT: op_d.simple_res = in_ch.operand_a >>> FRAC_BITS;
			default: op_d.unit = fpa_pkg::UNIT_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1 <= op_d;
		end
	end

	property p_flags_exclusive;
		@(posedge clk) disable iff (!arst_n)
			valid_s1 |-> $onehot({op_s1.less, op_s1.equal, op_s1.greater});
	endproperty
	a_flags_exclusive: assert property (p_flags_exclusive) else $error("flags not one-hot");

	property p_hold_on_stall;
		@(posedge clk) disable iff (!arst_n)
			valid_s1 && !op_ready |=> valid_s1 && $stable(op_s1);
	endproperty
	a_hold_on_stall: assert property (p_hold_on_stall) else $error("front item lost");

	property p_divzero_unit;
		@(posedge clk) disable iff (!arst_n)
			valid_s1 && op_s1.div_zero |-> op_s1.unit == fpa_pkg::UNIT_ZERO;
	endproperty
	a_divzero_unit: assert property (p_divzero_unit) else $error("div zero misrouted");

endmodule

// ===== src/fpa_queue.sv =====
// Short FIFO between front and back ends.
module fpa_queue #(
	parameter int unsigned DEPTH = fpa_pkg::QueueDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  fpa_pkg::op_t wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output fpa_pkg::op_t rd_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fpa_pkg::op_t       mem_q [DEPTH];
	logic [AW-1:0]      wptr_q, rptr_q;
	logic [AW:0]        count_q;
	logic               push, pop;

	assign wr_ready = count_q != (AW+1)'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data = mem_q[rptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= (AW+1)'(DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("queue overflow");

	property p_count_track;
		@(posedge clk) disable iff (!arst_n)
			push && !pop |=> count_q == $past(count_q) + (AW+1)'(1);
	endproperty
	a_count_track: assert property (p_count_track) else $error("queue count slip");

	property p_empty_pop;
		@(posedge clk) disable iff (!arst_n) count_q == '0 |-> !pop;
	endproperty
	a_empty_pop: assert property (p_empty_pop) else $error("pop from empty queue");

endmodule

// ===== src/fpa_back.sv =====
// Back end: pipelined multiply and radix-2 divide, results leave in order.
module fpa_back #(
	parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         op_valid,
	output logic         op_ready,
	input  fpa_pkg::op_t op,
	fpa_out_if.source    out_ch
);
	localparam int unsigned W = fpa_pkg::WordW;
	localparam int unsigned NW = W + FRAC_BITS;   // dividend width
	localparam int unsigned STEPS = NW;           // one quotient bit per stage
	localparam int unsigned PW = 2 * W;

	// Every item walks the same STEPS+2 stage pipe to keep order.
	localparam int unsigned DEPTH = STEPS + 2;

	typedef struct packed {
		fpa_pkg::unit_t   unit;
		logic [W-1:0]     simple_res;
		logic             less, equal, greater, div_zero;
		logic             neg;                 // quotient sign
		logic [NW-1:0]    num;                 // shifting dividend / quotient bits
		logic [W:0]       rem;
		logic [W-1:0]     den;
		logic [PW-1:0]    prod;
	} stg_t;

	stg_t          pipe_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic          advance;
	stg_t          entry;
	logic [W-1:0]  abs_a, abs_b;

	assign advance = !vld_q[DEPTH-1] || out_ch.ready;
	assign op_ready = advance;

	always_comb begin
		abs_a = op.a[W-1] ? W'(-op.a) : W'(op.a);
		abs_b = op.b[W-1] ? W'(-op.b) : W'(op.b);
		entry = '0;
		entry.unit = op.unit;
		entry.simple_res = op.simple_res;
		entry.less = op.less;
		entry.equal = op.equal;
		entry.greater = op.greater;
		entry.div_zero = op.div_zero;
		entry.neg = op.a[W-1] ^ op.b[W-1];
		entry.num = {abs_a, FRAC_BITS'(0)};
		entry.den = abs_b;
		entry.prod = PW'(op.a) * PW'(op.b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[DEPTH-2:0], op_valid};
		end
	end

	// Stages 1..STEPS: one restoring divide step each.
	always_ff @(posedge clk) begin
		if (advance) begin
			pipe_q[0] <= entry;
			for (int i = 1; i < DEPTH; i++) begin
				stg_t       nxt;
				logic [W:0] trial;
				nxt = pipe_q[i-1];
				if (i <= STEPS) begin
					trial = {pipe_q[i-1].rem[W-1:0], pipe_q[i-1].num[NW-1]};
					if (trial >= {1'b0, pipe_q[i-1].den}) begin
						nxt.rem = trial - {1'b0, pipe_q[i-1].den};
						nxt.num = {pipe_q[i-1].num[NW-2:0], 1'b1};
					end else begin
						nxt.rem = trial;
						nxt.num = {pipe_q[i-1].num[NW-2:0], 1'b0};
					end
				end
				pipe_q[i] <= nxt;
			end
		end
	end

	stg_t          last;
	logic [W-1:0]  mag;
	always_comb begin
		last = pipe_q[DEPTH-1];
		mag = last.num[W-1:0];
		out_ch.valid = vld_q[DEPTH-1];
		out_ch.a_less = last.less;
		out_ch.a_equal = last.equal;
		out_ch.a_greater = last.greater;
		out_ch.divide_error = last.div_zero;
		case (last.unit)
			fpa_pkg::UNIT_SIMPLE: out_ch.result = last.simple_res;
			fpa_pkg::UNIT_MUL: out_ch.result = last.prod[FRAC_BITS +: W];
			fpa_pkg::UNIT_DIV: out_ch.result = last.neg ? W'(-mag) : mag;
			default: out_ch.result = '0;
		endcase
	end

	property p_stall_hold;
		@(posedge clk) disable iff (!arst_n)
			out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result);
	endproperty
	a_stall_hold: assert property (p_stall_hold) else $error("result dropped on stall");

	property p_err_zero;
		@(posedge clk) disable iff (!arst_n)
			out_ch.valid && out_ch.divide_error |-> out_ch.result == '0;
	endproperty
	a_err_zero: assert property (p_err_zero) else $error("divide error with nonzero result");

	property p_ready_follows;
		@(posedge clk) disable iff (!arst_n) !vld_q[DEPTH-1] |-> op_ready;
	endproperty
	a_ready_follows: assert property (p_ready_follows) else $error("back stalled while empty");

endmodule

// ===== src/fixed_point_alu.sv =====
// Top level of the signed 32-bit fixed-point ALU.
// Channels: in_ch (command, operand_a, operand_b) and out_ch (result and flags),
// both valid/ready; a beat moves when valid and ready are high at a clock edge.
// One result beat per input beat, in order.
// Throughput: one item per cycle unless the receiver stalls. The multiply is
// formed as an item enters the back pipe, and divide runs as a pipeline of
// 32+FRAC_BITS restoring steps, one quotient bit a stage. Every item uses that
// same pipe so results stay in order. An accepted item passes the front stage,
// then the queue, then the 34+FRAC_BITS back stages before its result is valid.
// When the receiver stalls, the back pipe holds, the two-entry queue fills,
// then the front holds and in_ch.ready drops.
// Reset clears every valid bit; no result is pending afterwards.
module fixed_point_alu #(
	parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	fpa_in_if.sink     in_ch,
	fpa_out_if.source  out_ch
);
	logic         f_valid, f_ready, b_valid, b_ready;
	fpa_pkg::op_t f_op, b_op;

	fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_ch,
		.op_valid(f_valid), .op_ready(f_ready), .op(f_op)
	);

	fpa_queue #(.DEPTH(fpa_pkg::QueueDepth)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_op),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_op)
	);

	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.op_valid(b_valid), .op_ready(b_ready), .op(b_op), .out_ch
	);

endmodule

// ===== sim/tb_fpa_if.sv =====
// Answer record type shared by the fixed-point ALU testbench.
`timescale 1ns / 1ps
package tb_fpa_types;
	typedef struct packed {
		logic [31:0] result;
		logic        a_less;
		logic        a_equal;
		logic        a_greater;
		logic        divide_error;
	} alu_answer_t;
endpackage

// ===== sim/tb_fixed_point_alu.sv =====
// Testbench for the fixed-point ALU: random and directed beats checked against a predictor.
`timescale 1ns / 1ps
module tb_fixed_point_alu;

	localparam int FB = 8;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 200;

	class alu_scoreboard;
		tb_fpa_types::alu_answer_t pending[$];
		int mismatches;

		function tb_fpa_types::alu_answer_t compute(logic [3:0] cmd,
				logic signed [31:0] a, logic signed [31:0] b);
			tb_fpa_types::alu_answer_t r;
			logic signed [63:0] wide;
			logic signed [63:0] num;
			r = '0;
			r.a_less = a < b;
			r.a_equal = a == b;
			r.a_greater = a > b;
			case (cmd)
				fpa_pkg::CMD_ADD: r.result = a + b;
				fpa_pkg::CMD_SUB: r.result = a - b;
				fpa_pkg::CMD_MUL: begin
					wide = 64'(a) * 64'(b);
					r.result = 32'(wide >>> FB);
				end
				fpa_pkg::CMD_DIV: begin
					if (b == 0) r.divide_error = 1'b1;
					else begin
						num = 64'(a) <<< FB;
						wide = num / 64'(b);
						r.result = wide[31:0];
					end
				end
				fpa_pkg::CMD_INC: r.result = a + 32'sd1;
				fpa_pkg::CMD_DEC: r.result = a - 32'sd1;
				fpa_pkg::CMD_MIN: r.result = (a < b) ? a : b;
				fpa_pkg::CMD_MAX: r.result = (a > b) ? a : b;
				fpa_pkg::CMD_FROM_INT: r.result = a << FB;
				fpa_pkg::CMD_TO_INT: r.result = a >>> FB;
				default: r.result = '0;
			endcase
			return r;
		endfunction

		function void note_input(logic [3:0] cmd, logic signed [31:0] a, logic signed [31:0] b);
			pending.push_back(compute(cmd, a, b));
		endfunction

		function void check_result(tb_fpa_types::alu_answer_t got);
			tb_fpa_types::alu_answer_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected res=%h lt=%b eq=%b gt=%b de=%b, ",
						want.result, want.a_less, want.a_equal, want.a_greater,
						want.divide_error, "got res=%h lt=%b eq=%b gt=%b de=%b",
						got.result, got.a_less, got.a_equal, got.a_greater,
						got.divide_error);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	fpa_in_if in_ch();
	fpa_out_if out_ch();
	alu_scoreboard board = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_go = 1'b0;
	int hold_cnt = 0;
	int idle_cycles = 0;

	fixed_point_alu #(.FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	// Receiver: random stall, or one long hold-off counted here.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				board.check_result({out_ch.result, out_ch.a_less, out_ch.a_equal,
					out_ch.a_greater, out_ch.divide_error});
			if (hold_go && hold_cnt < HOLD_CYCLES) begin
				hold_cnt <= hold_cnt + 1;
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog on cycles with no beat moved.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return $signed(32'($urandom_range(2047)) - 32'sd1024);
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic send_beat(logic [3:0] cmd, logic signed [31:0] a, logic signed [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		board.note_input(cmd, a, b);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [3:0] cmd;
		logic signed [31:0] a;
		logic signed [31:0] b;
		in_ch.valid = 1'b0;
		in_ch.command = '0;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every command on extremes, zero divisor, divide overflow, unused codes.
		for (int c = 0; c < 10; c++)
			send_beat(c[3:0], 32'sh7fffffff, 32'sh80000000);
		send_beat(fpa_pkg::CMD_DIV, 32'sd1234, 32'sd0);
		send_beat(fpa_pkg::CMD_DIV, 32'sh80000000, 32'sd1);
		send_beat(fpa_pkg::CMD_DIV, 32'sh80000000, 32'shffffffff);
		send_beat(fpa_pkg::CMD_DIV, -32'sd777, 32'sd300);
		send_beat(fpa_pkg::CMD_MUL, 32'sh80000000, 32'sh80000000);
		send_beat(fpa_pkg::CMD_MUL, -32'sd3, 32'sd5);
		send_beat(fpa_pkg::CMD_MIN, 32'sd5, 32'sd5);
		send_beat(fpa_pkg::CMD_MAX, -32'sd9, -32'sd9);
		send_beat(fpa_pkg::CMD_INC, 32'sh7fffffff, 32'sd0);
		send_beat(fpa_pkg::CMD_DEC, 32'sh80000000, 32'sd0);
		send_beat(4'd10, 32'sd1, 32'sd2);
		send_beat(4'd15, 32'shffffffff, 32'shffffffff);
		send_beat(fpa_pkg::CMD_TO_INT, -32'sd1, 32'sd0);

		// Long receiver hold-off while the sender keeps offering past the block's capacity.
		hold_go = 1'b1;
		for (int i = 0; i < 80; i++)
			send_beat(4'($urandom_range(9)), pick_operand(), pick_operand());
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 59; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 59; end
				default: begin send_idle_pct = 9; stall_pct = 9; end
			endcase
			for (int i = 0; i < 135; i++) begin
				cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
					: 4'($urandom_range(9));
				a = pick_operand();
				b = ($urandom_range(9) == 0) ? a : pick_operand();
				if (cmd == fpa_pkg::CMD_DIV && $urandom_range(7) == 0) b = 32'sd0;
				send_beat(cmd, a, b);
			end
			if (phase == 1) drain();
		end
		drain();
		stall_pct = 0;
		repeat (60) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== fixed_point_alu.f =====
src/fpa_pkg.sv
src/fpa_if.sv
src/fpa_front.sv
src/fpa_queue.sv
src/fpa_back.sv
src/fixed_point_alu.sv
sim/tb_fpa_if.sv
sim/tb_fixed_point_alu.sv
